// File: rtl/core/mhe_pkg.sv
// mhe_pkg: shared types and constants for the murmur2 hash engine
// holds the controller/datapath command and status structs and the hash constants
// no dependencies

package mhe_pkg;

    // hash constants
    localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
    localparam int unsigned MIX_SHIFT   = 24;
    localparam int unsigned FIN_SHIFT_A = 13;
    localparam int unsigned FIN_SHIFT_B = 15;

    // field widths
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned VB_W    = 3;
    localparam int unsigned LEN_W   = 32;
    localparam int unsigned HASH_W  = 32;
    localparam int unsigned IN_TDATA_W  = 72;
    localparam int unsigned OUT_TDATA_W = 32;

    // bit positions in the input tdata
    localparam int unsigned VB_LSB  = WORD_W;
    localparam int unsigned LEN_LSB = WORD_W + VB_W;

    // full word count
    localparam logic [VB_W-1:0] VB_FULL = 3'd4;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_K1,
        ST_K2,
        ST_HMIX,
        ST_TAIL,
        ST_FIN,
        ST_DONE
    } t_state;

    // datapath operations, one multiply each except OP_NONE
    typedef enum logic [2:0] {
        OP_NONE,
        OP_K1,
        OP_K2,
        OP_HMIX,
        OP_TAIL,
        OP_FIN
    } t_op;

    // how an incoming word is handled
    typedef enum logic [1:0] {
        KIND_FULL,
        KIND_TAIL,
        KIND_EMPTY
    } t_kind;

    typedef struct packed {
        logic  load;
        t_op   op;
        logic  out_load;
    } t_cmd;

    typedef struct packed {
        t_kind in_kind;
        logic  last;
    } t_status;

endpackage

// File: rtl/core/mhe_datapath.sv
// mhe_datapath: hash registers, seed register and the shared constant multiplier
// executes one operation per cycle as commanded by mhe_ctrl
// depends on mhe_pkg

module mhe_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mhe_pkg::t_cmd                 i_cmd,
    output mhe_pkg::t_status              o_status,
    input  logic                          i_seed_we,
    input  logic [31:0]                   i_seed,
    input  logic [mhe_pkg::WORD_W-1:0]    i_data_word,
    input  logic [mhe_pkg::VB_W-1:0]      i_valid_bytes,
    input  logic                          i_last,
    input  logic [mhe_pkg::LEN_W-1:0]     i_message_length,
    output logic [mhe_pkg::HASH_W-1:0]    o_hash
);

    logic [31:0] r_seed;
    logic        r_mid;
    logic        r_last;
    logic [31:0] r_w;
    logic [31:0] r_k;
    logic [31:0] r_h;
    logic [31:0] r_hash;

    logic [31:0]   mul_a;
    logic [31:0]   prod;
    logic [31:0]   base_h;
    logic [31:0]   tail_mask;
    mhe_pkg::t_kind in_kind;

    // classify the incoming word and build the tail byte mask
    always_comb begin
        tail_mask = 32'h0;
        if (!i_last || i_valid_bytes >= mhe_pkg::VB_FULL) begin
            in_kind = mhe_pkg::KIND_FULL;
        end else if (i_valid_bytes == 3'd0) begin
            in_kind = mhe_pkg::KIND_EMPTY;
        end else begin
            in_kind = mhe_pkg::KIND_TAIL;
            case (i_valid_bytes)
                3'd1:    tail_mask = 32'h0000_00ff;
                3'd2:    tail_mask = 32'h0000_ffff;
                default: tail_mask = 32'h00ff_ffff;
            endcase
        end
    end

    // start value: seed and length on the first word, running hash after that
    assign base_h = r_mid ? r_h : (r_seed ^ i_message_length);

    // shared multiplier operand select
    always_comb begin
        case (i_cmd.op)
            mhe_pkg::OP_K1:  mul_a = r_w;
            mhe_pkg::OP_K2:  mul_a = r_k ^ (r_k >> mhe_pkg::MIX_SHIFT);
            mhe_pkg::OP_FIN: mul_a = r_h ^ (r_h >> mhe_pkg::FIN_SHIFT_A);
            default:         mul_a = r_h;
        endcase
    end

    assign prod = mul_a * mhe_pkg::MIX_MUL;

    // control-side state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= 32'h0;
            r_mid  <= 1'b0;
        end else begin
            if (i_seed_we) begin
                r_seed <= i_seed;
            end
            if (i_cmd.load) begin
                r_mid <= !i_last;
            end
        end
    end

    // hash working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_w    <= i_data_word;
            r_last <= i_last;
            r_h    <= base_h ^ (i_data_word & tail_mask);
        end
        case (i_cmd.op)
            mhe_pkg::OP_K1,
            mhe_pkg::OP_K2:   r_k <= prod;
            mhe_pkg::OP_HMIX: r_h <= prod ^ r_k;
            mhe_pkg::OP_TAIL,
            mhe_pkg::OP_FIN:  r_h <= prod;
            default: ;
        endcase
        if (i_cmd.out_load) begin
            r_hash <= r_h ^ (r_h >> mhe_pkg::FIN_SHIFT_B);
        end
    end

    assign o_status.in_kind = in_kind;
    assign o_status.last    = r_last;
    assign o_hash           = r_hash;

endmodule

// File: rtl/core/mhe_ctrl.sv
// mhe_ctrl: sequencer for the murmur2 hash engine
// steps one word through the shared multiplier and owns the output valid flag
// depends on mhe_pkg

module mhe_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  mhe_pkg::t_status  i_status,
    output mhe_pkg::t_cmd     o_cmd
);

    mhe_pkg::t_state r_state;
    mhe_pkg::t_state n_state;
    logic            r_out_valid;
    logic            n_out_valid;
    logic            accept;

    assign o_in_ready = (r_state == mhe_pkg::ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mhe_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and commands
    always_comb begin
        n_state        = r_state;
        o_cmd.load     = 1'b0;
        o_cmd.op       = mhe_pkg::OP_NONE;
        o_cmd.out_load = 1'b0;
        case (r_state)
            mhe_pkg::ST_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    case (i_status.in_kind)
                        mhe_pkg::KIND_FULL:  n_state = mhe_pkg::ST_K1;
                        mhe_pkg::KIND_TAIL:  n_state = mhe_pkg::ST_TAIL;
                        default:             n_state = mhe_pkg::ST_FIN;
                    endcase
                end
            end
            mhe_pkg::ST_K1: begin
                o_cmd.op = mhe_pkg::OP_K1;
                n_state  = mhe_pkg::ST_K2;
            end
            mhe_pkg::ST_K2: begin
                o_cmd.op = mhe_pkg::OP_K2;
                n_state  = mhe_pkg::ST_HMIX;
            end
            mhe_pkg::ST_HMIX: begin
                o_cmd.op = mhe_pkg::OP_HMIX;
                n_state  = i_status.last ? mhe_pkg::ST_FIN : mhe_pkg::ST_IDLE;
            end
            mhe_pkg::ST_TAIL: begin
                o_cmd.op = mhe_pkg::OP_TAIL;
                n_state  = mhe_pkg::ST_FIN;
            end
            mhe_pkg::ST_FIN: begin
                o_cmd.op = mhe_pkg::OP_FIN;
                n_state  = mhe_pkg::ST_DONE;
            end
            mhe_pkg::ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = mhe_pkg::ST_IDLE;
                end
            end
            default: n_state = mhe_pkg::ST_IDLE;
        endcase
    end

    // output valid: set on load, cleared when the result transfer completes
    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    // a full word always starts the key multiply next
    a_full_starts_k1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_status.in_kind == mhe_pkg::KIND_FULL |=> r_state == mhe_pkg::ST_K1)
        else $error("full word did not enter key multiply");

    // finalization never overlaps with taking a new word
    a_fin_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == mhe_pkg::ST_FIN |=> r_state == mhe_pkg::ST_DONE && !o_in_ready)
        else $error("input taken during finalization");

    // a loaded result is presented on the next cycle
    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> r_out_valid)
        else $error("result loaded but not presented");

    // a non-last full word returns to idle after mixing
    a_mid_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == mhe_pkg::ST_HMIX && !i_status.last |=> o_in_ready && !o_cmd.out_load)
        else $error("mid-message word did not return to idle");

endmodule

// File: rtl/core/murmur2_hash_engine_top.sv
// murmur2_hash_engine_top: streaming 32-bit MurmurHash2 engine
// Takes a message as 32-bit little-endian words and returns one hash per message on the
// result stream. The first word of a message starts the hash from seed XOR message_length;
// message_length is ignored on later words and valid_bytes is read only on the last word.
// All mixing goes through one shared 32x32 constant multiplier, one multiply per cycle.
// Each word starts with accept; a full word then takes key multiply, key remix and hash
// multiply, a tail word of 1 to 3 bytes a tail multiply, and a last word ends with
// finalization and a result load that waits for the result register to drain. The result
// register lets the next message start while a hash waits to be taken. The seed may be
// written at any time the engine is idle and applies from the next message start.
// depends on mhe_pkg, mhe_ctrl, mhe_datapath

module murmur2_hash_engine_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // seed register write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data,
    // message word stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [31:0] data_word, [34:32] valid_bytes, [66:35] message_length, [71:67] zero
    input  logic [mhe_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic        s_axis_tlast,
    // hash result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] hash
    output logic [mhe_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    mhe_pkg::t_cmd    cmd;
    mhe_pkg::t_status status;
    logic [mhe_pkg::HASH_W-1:0] hash;

    assign o_cfg_ready = 1'b1;

    mhe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    mhe_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_seed_we        (i_cfg_valid && o_cfg_ready),
        .i_seed           (i_cfg_data),
        .i_data_word      (s_axis_tdata[mhe_pkg::WORD_W-1:0]),
        .i_valid_bytes    (s_axis_tdata[mhe_pkg::VB_LSB +: mhe_pkg::VB_W]),
        .i_last           (s_axis_tlast),
        .i_message_length (s_axis_tdata[mhe_pkg::LEN_LSB +: mhe_pkg::LEN_W]),
        .o_hash           (hash)
    );

    assign m_axis_tdata = hash;

endmodule
